@@ rtl/core/i2c_eeprom_transfer_sequencer_defines.svh @@
// assertion macros shared by the sequencer modules
`ifndef I2C_EEPROM_TRANSFER_SEQUENCER_DEFINES_SVH
`define I2C_EEPROM_TRANSFER_SEQUENCER_DEFINES_SVH

// same-cycle implication
`define IESEQ_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define IESEQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/ieseq_pkg.sv @@
// types and constants of the serial eeprom transfer sequencer
package ieseq_pkg;

   localparam int ADDR_W      = 16;
   localparam int BYTE_W      = 8;
   localparam int DEV_W       = 7;
   localparam int CSR_DATA_W  = 7;
   localparam int CSR_INDEX_W = 1;
   localparam int NUM_SLOTS   = 10;

   typedef enum logic [2:0] {
      CMD_START     = 3'd0,
      CMD_SEND      = 3'd1,
      CMD_READ_ACK  = 3'd2,
      CMD_READ_NACK = 3'd3,
      CMD_STOP      = 3'd4,
      CMD_WAIT      = 3'd5
   } cmd_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_DEVICE_ADDRESS      = 1'b0,
      CSR_TWO_BYTE_ADDRESSING = 1'b1
   } csr_index_type;

   localparam logic FUNC_READ  = 1'b0;
   localparam logic FUNC_WRITE = 1'b1;

   // fixed positions of the commands one transaction can cause
   localparam logic [3:0] SLOT_CLOSE     = 4'd0;
   localparam logic [3:0] SLOT_START     = 4'd1;
   localparam logic [3:0] SLOT_DEVICE    = 4'd2;
   localparam logic [3:0] SLOT_ADDR_HI   = 4'd3;
   localparam logic [3:0] SLOT_ADDR_LO   = 4'd4;
   localparam logic [3:0] SLOT_RESTART   = 4'd5;
   localparam logic [3:0] SLOT_DEVICE_RD = 4'd6;
   localparam logic [3:0] SLOT_DATA      = 4'd7;
   localparam logic [3:0] SLOT_STOP      = 4'd8;
   localparam logic [3:0] SLOT_WAIT      = 4'd9;

   typedef struct packed {
      logic              func;
      logic              first;
      logic [ADDR_W-1:0] address;
      logic [BYTE_W-1:0] data;
      logic              last;
   } item_type;

   typedef struct packed {
      logic    [NUM_SLOTS-1:0]             valid;
      cmd_type [NUM_SLOTS-1:0]             cmd;
      logic    [NUM_SLOTS-1:0][BYTE_W-1:0] bus_byte;
   } seq_type;

endpackage

@@ rtl/core/ieseq_if.sv @@
// request and response channel interfaces
interface ieseq_req_if
   import ieseq_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic              func;
   logic              first;
   logic [ADDR_W-1:0] address;
   logic [BYTE_W-1:0] data;
   logic              last;

   modport source (output valid, func, first, address, data, last, input ready);
   modport sink   (input valid, func, first, address, data, last, output ready);
endinterface

interface ieseq_rsp_if
   import ieseq_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [2:0]        cmd;
   logic [BYTE_W-1:0] bus_byte;
   logic              end_of_run;

   modport source (output valid, cmd, bus_byte, end_of_run, input ready);
   modport sink   (input valid, cmd, bus_byte, end_of_run, output ready);
endinterface

@@ rtl/core/ieseq_input_stage.sv @@
// input register with the page remainder of the request address
module ieseq_input_stage
   import ieseq_pkg::*;
#(
   parameter  int PAGE_BYTES = 8,
   localparam int RemW       = (PAGE_BYTES > 1) ? $clog2(PAGE_BYTES) : 1
) (
   input  logic            clock,
   input  logic            reset,
   ieseq_req_if.sink       req,
   input  logic            advance,
   output logic            item_valid,
   output item_type        item,
   output logic [RemW-1:0] addr_rem
);

   typedef logic [255:0][RemW-1:0] rem_tab_type;

   function automatic rem_tab_type build_hi_tab();
      rem_tab_type tab;
      for (int i = 0; i < 256; i++) begin
         tab[i] = RemW'((i * 256) % PAGE_BYTES);
      end
      return tab;
   endfunction

   function automatic rem_tab_type build_lo_tab();
      rem_tab_type tab;
      for (int i = 0; i < 256; i++) begin
         tab[i] = RemW'(i % PAGE_BYTES);
      end
      return tab;
   endfunction

   localparam rem_tab_type HiTab = build_hi_tab();
   localparam rem_tab_type LoTab = build_lo_tab();
   localparam logic [RemW:0] PageLimit = (RemW+1)'(PAGE_BYTES);

   logic            valid_ff, valid_in;
   item_type        item_ff;
   logic [RemW-1:0] rem_ff, rem_in;
   logic [RemW:0]   rem_sum;
   logic            take;

   assign req.ready  = !valid_ff || advance;
   assign take       = req.valid && req.ready;
   assign item_valid = valid_ff;
   assign item       = item_ff;
   assign addr_rem   = rem_ff;

   // address mod page size from its two bytes
   always_comb begin
      rem_sum = {1'b0, HiTab[req.address[15:8]]} + {1'b0, LoTab[req.address[7:0]]};
      if (rem_sum >= PageLimit) begin
         rem_in = RemW'(rem_sum - PageLimit);
      end else begin
         rem_in = RemW'(rem_sum);
      end
   end

   always_comb begin
      if (take) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= '{func: req.func, first: req.first, address: req.address,
                      data: req.data, last: req.last};
         rem_ff  <= rem_in;
      end
   end

endmodule

@@ rtl/core/ieseq_planner.sv @@
// transfer state and command list for one transaction
`include "i2c_eeprom_transfer_sequencer_defines.svh"

module ieseq_planner
   import ieseq_pkg::*;
#(
   parameter  int PAGE_BYTES = 8,
   localparam int RemW       = (PAGE_BYTES > 1) ? $clog2(PAGE_BYTES) : 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             item_valid,
   input  item_type         item,
   input  logic [RemW-1:0]  addr_rem,
   input  logic             advance,
   input  logic [DEV_W-1:0] device_address,
   input  logic             two_byte_addressing,
   output seq_type          plan
);

   localparam logic [RemW-1:0] RemLast = RemW'(PAGE_BYTES - 1);

   logic [ADDR_W-1:0] next_address_ff, next_address_in;
   logic [RemW-1:0]   page_rem_ff, page_rem_in;
   logic              open_ff, open_in;
   logic              kind_ff;

   logic              close_old, open_new, boundary;
   logic              read_close, write_close;
   logic [ADDR_W-1:0] base;
   logic [RemW-1:0]   base_rem;
   logic [BYTE_W-1:0] dev_w, dev_one;

   always_comb begin
      close_old   = open_ff && (item.first || (item.func != kind_ff));
      open_new    = !(open_ff && !close_old);
      base        = item.first ? item.address : next_address_ff;
      base_rem    = item.first ? addr_rem : page_rem_ff;
      next_address_in = base + 16'd1;
      // address wrap to zero restarts the page count
      page_rem_in = ((base_rem == RemLast) || (base == '1)) ? '0 : base_rem + 1'b1;
      boundary    = (page_rem_in == '0);
      read_close  = (item.func == FUNC_READ) && item.last;
      write_close = (item.func == FUNC_WRITE) && (item.last || boundary);
      open_in     = !(read_close || write_close);
      dev_w       = {device_address, 1'b0};
      dev_one     = dev_w + {base[14:8], 1'b0};
   end

   always_comb begin
      plan = '0;
      plan.valid[SLOT_CLOSE] = close_old;
      plan.cmd[SLOT_CLOSE]   = CMD_STOP;

      plan.valid[SLOT_START] = open_new;
      plan.cmd[SLOT_START]   = CMD_START;

      plan.valid[SLOT_DEVICE]    = open_new;
      plan.cmd[SLOT_DEVICE]      = CMD_SEND;
      plan.bus_byte[SLOT_DEVICE] = two_byte_addressing ? dev_w : dev_one;

      plan.valid[SLOT_ADDR_HI]    = open_new && two_byte_addressing;
      plan.cmd[SLOT_ADDR_HI]      = CMD_SEND;
      plan.bus_byte[SLOT_ADDR_HI] = base[15:8];

      plan.valid[SLOT_ADDR_LO]    = open_new;
      plan.cmd[SLOT_ADDR_LO]      = CMD_SEND;
      plan.bus_byte[SLOT_ADDR_LO] = base[7:0];

      plan.valid[SLOT_RESTART] = open_new && (item.func == FUNC_READ);
      plan.cmd[SLOT_RESTART]   = CMD_START;

      plan.valid[SLOT_DEVICE_RD]    = open_new && (item.func == FUNC_READ);
      plan.cmd[SLOT_DEVICE_RD]      = CMD_SEND;
      plan.bus_byte[SLOT_DEVICE_RD] = dev_w | 8'h01;

      plan.valid[SLOT_DATA] = 1'b1;
      if (item.func == FUNC_WRITE) begin
         plan.cmd[SLOT_DATA]      = CMD_SEND;
         plan.bus_byte[SLOT_DATA] = item.data;
      end else if (item.last) begin
         plan.cmd[SLOT_DATA] = CMD_READ_NACK;
      end else begin
         plan.cmd[SLOT_DATA] = CMD_READ_ACK;
      end

      plan.valid[SLOT_STOP] = read_close || write_close;
      plan.cmd[SLOT_STOP]   = CMD_STOP;

      plan.valid[SLOT_WAIT] = write_close;
      plan.cmd[SLOT_WAIT]   = CMD_WAIT;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_address_ff <= '0;
         page_rem_ff     <= '0;
         open_ff         <= 1'b0;
         kind_ff         <= FUNC_READ;
      end else if (advance) begin
         next_address_ff <= next_address_in;
         page_rem_ff     <= page_rem_in;
         open_ff         <= open_in;
         kind_ff         <= item.func;
      end
   end

   `IESEQ_ASSERT_NEXT(a_read_last_closes, clock, reset,
      advance && (item.func == FUNC_READ) && item.last, !open_ff,
      "read with last left the transfer open")
   `IESEQ_ASSERT_IMPL(a_idle_bus_opens, clock, reset, item_valid && !open_ff,
      plan.valid[SLOT_START] && !plan.valid[SLOT_CLOSE],
      "transaction on idle bus without address phase")

endmodule

@@ rtl/core/ieseq_emitter.sv @@
// command slot register, one bus command per cycle while the receiver is ready
`include "i2c_eeprom_transfer_sequencer_defines.svh"

module ieseq_emitter
   import ieseq_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  seq_type    plan,
   input  logic       load,
   output logic       can_load,
   ieseq_rsp_if.source rsp
);

   logic    [NUM_SLOTS-1:0]             slot_valid_ff, slot_valid_in;
   cmd_type [NUM_SLOTS-1:0]             cmd_ff;
   logic    [NUM_SLOTS-1:0][BYTE_W-1:0] byte_ff;

   logic [NUM_SLOTS-1:0] pick, remaining;
   logic                 final_cmd, pop;
   logic [2:0]           sel_cmd;
   logic [BYTE_W-1:0]    sel_byte;

   // lowest pending slot goes out first
   always_comb begin
      pick      = slot_valid_ff & (~slot_valid_ff + NUM_SLOTS'(1));
      remaining = slot_valid_ff & ~pick;
      final_cmd = (remaining == '0);
      sel_cmd   = '0;
      sel_byte  = '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         sel_cmd  = sel_cmd | (cmd_ff[i] & {3{pick[i]}});
         sel_byte = sel_byte | (byte_ff[i] & {BYTE_W{pick[i]}});
      end
   end

   assign rsp.valid      = |slot_valid_ff;
   assign rsp.cmd        = sel_cmd;
   assign rsp.bus_byte   = sel_byte;
   assign rsp.end_of_run = final_cmd;
   assign pop            = rsp.valid && rsp.ready;
   assign can_load       = !rsp.valid || (rsp.ready && final_cmd);

   always_comb begin
      if (load) begin
         slot_valid_in = plan.valid;
      end else if (pop) begin
         slot_valid_in = remaining;
      end else begin
         slot_valid_in = slot_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= '0;
      end else begin
         slot_valid_ff <= slot_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         cmd_ff  <= plan.cmd;
         byte_ff <= plan.bus_byte;
      end
   end

   `IESEQ_ASSERT_NEXT(a_load_shows_cmd, clock, reset, load, rsp.valid, "loaded transaction produced no command")
   `IESEQ_ASSERT_IMPL(a_slot_bound, clock, reset, rsp.valid, $countones(slot_valid_ff) <= 9, "more than nine commands pending")

endmodule

@@ rtl/core/i2c_eeprom_transfer_sequencer.sv @@
// top level of the serial eeprom transfer sequencer
//
//   channel  dir  handshake     payload
//   req_ch   in   valid/ready   func, first, address, data, last
//   rsp_ch   out  valid/ready   cmd, bus_byte, end_of_run
//   csr      in   csr_we        csr_index, csr_wdata
//
// each transaction gives one to nine bus commands, one per cycle from the slot register
// first command can be taken after the input register, then the slot register
// next transaction enters the slot register in the cycle its predecessor's last command goes
// reset is synchronous: transfer closed, address zero, csr registers at their defaults
// a stalled rsp_ch holds the command; req_ch buffers one transaction behind it
module i2c_eeprom_transfer_sequencer
   import ieseq_pkg::*;
#(
   parameter int PAGE_BYTES = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   ieseq_req_if.sink              req_ch,
   ieseq_rsp_if.source            rsp_ch,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int RemW = (PAGE_BYTES > 1) ? $clog2(PAGE_BYTES) : 1;

   logic [DEV_W-1:0] device_address_ff;
   logic             two_byte_ff;

   logic            item_valid, can_load, advance;
   item_type        item;
   logic [RemW-1:0] addr_rem;
   seq_type         plan;

   always_ff @(posedge clock) begin
      if (reset) begin
         device_address_ff <= 7'd80;
         two_byte_ff       <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_DEVICE_ADDRESS: begin
               device_address_ff <= csr_wdata[DEV_W-1:0];
            end
            CSR_TWO_BYTE_ADDRESSING: begin
               two_byte_ff <= csr_wdata[0];
            end
            default: begin
            end
         endcase
      end
   end

   assign advance = item_valid && can_load;

   ieseq_input_stage #(
      .PAGE_BYTES (PAGE_BYTES)
   ) u_input (
      .clock      (clock),
      .reset      (reset),
      .req        (req_ch),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item),
      .addr_rem   (addr_rem)
   );

   ieseq_planner #(
      .PAGE_BYTES (PAGE_BYTES)
   ) u_planner (
      .clock               (clock),
      .reset               (reset),
      .item_valid          (item_valid),
      .item                (item),
      .addr_rem            (addr_rem),
      .advance             (advance),
      .device_address      (device_address_ff),
      .two_byte_addressing (two_byte_ff),
      .plan                (plan)
   );

   ieseq_emitter u_emitter (
      .clock    (clock),
      .reset    (reset),
      .plan     (plan),
      .load     (advance),
      .can_load (can_load),
      .rsp      (rsp_ch)
   );

endmodule

@@ sim/i2c_eeprom_transfer_sequencer_tb.sv @@
// self-checking testbench for the serial eeprom transfer sequencer
module i2c_eeprom_transfer_sequencer_tb;
   import ieseq_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int PAGE_BYTES  = 8;
   localparam int HOLD_CYCLES = 90;
   localparam int SETTLE      = 6;

   typedef struct packed {
      cmd_type           cmd;
      logic [BYTE_W-1:0] bus_byte;
      logic              end_of_run;
   } bus_cmd_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   ieseq_req_if req_ch ();
   ieseq_rsp_if rsp_ch ();

   i2c_eeprom_transfer_sequencer #(.PAGE_BYTES(PAGE_BYTES)) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // shadow of the block's registers and transfer state
   logic [DEV_W-1:0]  dev_addr_cfg = 7'd80;
   logic              two_byte_cfg = 1'b0;
   logic [ADDR_W-1:0] run_addr = '0;
   logic              xfer_open = 1'b0;
   logic              open_func = FUNC_READ;

   item_type    pending_items [$];
   bus_cmd_type cmd_expect [$];

   int   error_count = 0;
   int   req_gap = 0;
   int   rsp_gap = 0;
   int   req_gap_max = 5;
   int   rsp_gap_max = 5;
   logic req_fire = 1'b0;
   logic rsp_fire = 1'b0;
   logic rsp_holding = 1'b0;
   event rsp_hold_go;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_error(input string what);
      $display("ERROR %0t ns: %s", $time, what);
      error_count++;
   endtask

   function automatic bus_cmd_type make_cmd(input cmd_type c, input logic [BYTE_W-1:0] b);
      bus_cmd_type r;
      r.cmd        = c;
      r.bus_byte   = b;
      r.end_of_run = 1'b0;
      return r;
   endfunction

   // bus commands caused by one accepted transaction
   task automatic predict_commands(input item_type it);
      bus_cmd_type       burst [0:NUM_SLOTS-1];
      int                n;
      logic [BYTE_W-1:0] dev_wr;
      n      = 0;
      dev_wr = {dev_addr_cfg, 1'b0};
      if (xfer_open && (it.first || it.func != open_func)) begin
         burst[n++] = make_cmd(CMD_STOP, 8'h00);
         xfer_open  = 1'b0;
      end
      if (it.first)
         run_addr = it.address;
      if (!xfer_open) begin
         burst[n++] = make_cmd(CMD_START, 8'h00);
         if (two_byte_cfg) begin
            burst[n++] = make_cmd(CMD_SEND, dev_wr);
            burst[n++] = make_cmd(CMD_SEND, run_addr[15:8]);
         end else begin
            burst[n++] = make_cmd(CMD_SEND, dev_wr + {run_addr[14:8], 1'b0});
         end
         burst[n++] = make_cmd(CMD_SEND, run_addr[7:0]);
         if (it.func == FUNC_READ) begin
            burst[n++] = make_cmd(CMD_START, 8'h00);
            burst[n++] = make_cmd(CMD_SEND, dev_wr | 8'h01);
         end
         xfer_open = 1'b1;
         open_func = it.func;
      end
      run_addr = run_addr + 1'b1;
      if (it.func == FUNC_READ) begin
         if (it.last) begin
            burst[n++] = make_cmd(CMD_READ_NACK, 8'h00);
            burst[n++] = make_cmd(CMD_STOP, 8'h00);
            xfer_open  = 1'b0;
         end else begin
            burst[n++] = make_cmd(CMD_READ_ACK, 8'h00);
         end
      end else begin
         burst[n++] = make_cmd(CMD_SEND, it.data);
         if (it.last || (run_addr % PAGE_BYTES) == 0) begin
            burst[n++] = make_cmd(CMD_STOP, 8'h00);
            burst[n++] = make_cmd(CMD_WAIT, 8'h00);
            xfer_open  = 1'b0;
         end
      end
      burst[n-1].end_of_run = 1'b1;
      for (int i = 0; i < n; i++)
         cmd_expect.push_back(burst[i]);
   endtask

   // request driver
   always @(negedge clock) begin
      item_type it;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_fire) begin
         if (req_gap > 0) begin
            req_ch.valid <= 1'b0;
            req_gap--;
         end else if (pending_items.size() > 0) begin
            it = pending_items.pop_front();
            req_ch.valid   <= 1'b1;
            req_ch.func    <= it.func;
            req_ch.first   <= it.first;
            req_ch.address <= it.address;
            req_ch.data    <= it.data;
            req_ch.last    <= it.last;
            req_gap = $urandom_range(req_gap_max, 0);
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // response receiver
   always @(negedge clock) begin
      if (rsp_fire)
         rsp_gap = $urandom_range(rsp_gap_max, 0);
      if (rsp_holding) begin
         rsp_ch.ready <= 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_ch.ready <= 1'b0;
         rsp_gap--;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // long receiver hold-off
   always begin
      @(rsp_hold_go);
      @(posedge clock);
      rsp_holding = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_holding = 1'b0;
   end

   // monitor: check commands, then predict from accepted transactions
   always @(posedge clock) begin
      bus_cmd_type want;
      req_fire <= !reset && req_ch.valid && req_ch.ready;
      rsp_fire <= !reset && rsp_ch.valid && rsp_ch.ready;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (cmd_expect.size() == 0) begin
            report_error($sformatf("command %0d with nothing expected", rsp_ch.cmd));
         end else begin
            want = cmd_expect.pop_front();
            if (rsp_ch.cmd !== want.cmd)
               report_error($sformatf("cmd %0d, expected %0d", rsp_ch.cmd, want.cmd));
            if (rsp_ch.bus_byte !== want.bus_byte)
               report_error($sformatf("bus_byte %02h, expected %02h",
                                      rsp_ch.bus_byte, want.bus_byte));
            if (rsp_ch.end_of_run !== want.end_of_run)
               report_error($sformatf("end_of_run %0b, expected %0b",
                                      rsp_ch.end_of_run, want.end_of_run));
         end
      end
      if (!reset && req_ch.valid && req_ch.ready)
         predict_commands({req_ch.func, req_ch.first, req_ch.address, req_ch.data,
                           req_ch.last});
   end

   task automatic add_item(input logic func, input logic first, input logic [ADDR_W-1:0] addr,
                           input logic [BYTE_W-1:0] data, input logic last);
      item_type it;
      it.func    = func;
      it.first   = first;
      it.address = addr;
      it.data    = data;
      it.last    = last;
      pending_items.push_back(it);
   endtask

   // mostly well-formed transfers, some noise and some left open
   task automatic add_random_traffic(input int count);
      int                made;
      int                len;
      int                kind;
      logic              f;
      logic [ADDR_W-1:0] start;
      made = 0;
      while (made < count) begin
         kind = $urandom_range(9, 0);
         if (kind < 2) begin
            add_item(1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)),
                     16'($urandom_range(65535, 0)), 8'($urandom_range(255, 0)),
                     1'($urandom_range(1, 0)));
            made++;
         end else begin
            f     = 1'($urandom_range(1, 0));
            start = 16'($urandom_range(65535, 0));
            len   = $urandom_range(12, 1);
            for (int i = 0; i < len; i++)
               add_item(f, i == 0, start, 8'($urandom_range(255, 0)),
                        (i == len - 1) && kind != 9);
            made += len;
         end
      end
   endtask

   task automatic drain();
      @(posedge clock);
      while (pending_items.size() != 0 || req_ch.valid || cmd_expect.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_DEVICE_ADDRESS)
         dev_addr_cfg = value[DEV_W-1:0];
      else
         two_byte_cfg = value[0];
   endtask

   task automatic configure(input logic [DEV_W-1:0] dev, input logic two_byte,
                            input int req_max, input int rsp_max);
      write_csr(CSR_DEVICE_ADDRESS, dev);
      write_csr(CSR_TWO_BYTE_ADDRESSING, {{(CSR_DATA_W-1){1'b0}}, two_byte});
      req_gap_max = req_max;
      rsp_gap_max = rsp_max;
      @(posedge clock);
   endtask

   initial begin
      req_ch.valid   = 1'b0;
      req_ch.func    = FUNC_READ;
      req_ch.first   = 1'b0;
      req_ch.address = '0;
      req_ch.data    = '0;
      req_ch.last    = 1'b0;
      rsp_ch.ready   = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed transactions at the reset settings
      add_item(FUNC_WRITE, 1'b1, 16'h0005, 8'h00, 1'b0);
      add_item(FUNC_WRITE, 1'b0, 16'h0000, 8'hFF, 1'b0);
      add_item(FUNC_WRITE, 1'b0, 16'hFFFF, 8'hA5, 1'b0);
      add_item(FUNC_WRITE, 1'b0, 16'h0000, 8'h5A, 1'b0);
      add_item(FUNC_WRITE, 1'b0, 16'h0000, 8'h3C, 1'b1);
      add_item(FUNC_READ,  1'b1, 16'hFFFF, 8'hFF, 1'b0);
      add_item(FUNC_READ,  1'b0, 16'h0000, 8'h00, 1'b0);
      add_item(FUNC_WRITE, 1'b0, 16'h0000, 8'h81, 1'b0);
      add_item(FUNC_READ,  1'b0, 16'h0000, 8'h00, 1'b0);
      add_item(FUNC_READ,  1'b1, 16'h1234, 8'h00, 1'b0);
      add_item(FUNC_READ,  1'b0, 16'h0000, 8'h00, 1'b1);
      add_item(FUNC_READ,  1'b0, 16'h0000, 8'h00, 1'b1);
      add_item(FUNC_WRITE, 1'b1, 16'hF800, 8'h7E, 1'b0);
      add_item(FUNC_WRITE, 1'b1, 16'h07FF, 8'h01, 1'b0);
      add_item(FUNC_WRITE, 1'b1, 16'h0000, 8'hFF, 1'b1);
      add_item(FUNC_WRITE, 1'b0, 16'h0000, 8'h10, 1'b0);
      add_item(FUNC_READ,  1'b1, 16'hAAAA, 8'h00, 1'b1);
      add_item(FUNC_WRITE, 1'b1, 16'h5555, 8'hC3, 1'b1);
      drain();

      configure(7'($urandom_range(127, 0)), 1'b0, 5, 5);
      add_random_traffic(120);
      drain();

      // sender keeps offering while the receiver holds off
      configure(7'd127, 1'b1, 0, 3);
      add_random_traffic(120);
      -> rsp_hold_go;
      drain();

      configure(7'd0, 1'b1, 0, 0);
      add_random_traffic(120);
      drain();

      configure(7'd127, 1'b0, 5, 5);
      add_random_traffic(120);
      drain();

      if (cmd_expect.size() != 0)
         report_error($sformatf("%0d commands never arrived", cmd_expect.size()));
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      #4_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
